/* hw/rtl/qrv_pkg.sv */
// package: item types and derived widths for the quaternion vector rotation pipeline
package qrv_pkg;

  // field widths
  localparam int QUAT_WIDTH = 16;
  localparam int VEC_WIDTH  = 16;
  localparam int QUAT_FRAC  = QUAT_WIDTH - 1;

  // internal widths
  localparam int PROD_W = 2 * QUAT_WIDTH;        // quaternion pair product
  localparam int SUM_W  = PROD_W + 1;            // sum of two products
  localparam int MAT_W  = SUM_W - (QUAT_FRAC - 1); // rotation matrix term
  localparam int MV_W   = MAT_W + VEC_WIDTH;     // matrix term times vector component
  localparam int DOT_W  = MV_W + 2;              // sum of three such products
  localparam int RES_W  = DOT_W - QUAT_FRAC;     // rounded row result before clipping

  // rounding offsets and the diagonal one
  localparam logic [SUM_W-1:0] OFF_RND  = SUM_W'(1) << (QUAT_FRAC - 2);
  localparam logic [DOT_W-1:0] DOT_RND  = DOT_W'(1) << (QUAT_FRAC - 1);
  localparam logic [MAT_W-1:0] DIAG_ONE = MAT_W'(1) << QUAT_FRAC;

  // input item
  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] qw;
    logic signed [QUAT_WIDTH-1:0] qx;
    logic signed [QUAT_WIDTH-1:0] qy;
    logic signed [QUAT_WIDTH-1:0] qz;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        saturated;
  } out_item_t;

endpackage

/* hw/rtl/quaternion_rotate_vector_unit.sv */
// top level: four-stage pipeline that rotates a vector by a quaternion
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | into unit | in_valid/in_stall   | in_data  (qw qx qy qz vec_x/y/z)
//  out     | from unit | out_valid/out_stall | out_data (rot_x/y/z saturated)
//
// one item per clock while out_stall is low; out_valid rises when the item reaches the stage 4 register
// stages: quaternion products, matrix terms, matrix-vector products, row sums and clip
// each stage has its own valid bit and loads when empty or when the next stage loads
// a stall on the output fills the pipeline before in_stall rises; nothing is dropped
// synchronous active-high rst clears the valid bits only
module quaternion_rotate_vector_unit
  import qrv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // stage valid bits and load enables
  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;

  // stage 1 registers: pair products and the vector
  logic signed [PROD_W-1:0]    p_wx, p_wy, p_wz, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
  logic signed [VEC_WIDTH-1:0] vec1 [3];

  // stage 2 registers: matrix terms, row major
  logic signed [MAT_W-1:0]     mat [9];
  logic signed [VEC_WIDTH-1:0] vec2 [3];

  // stage 3 registers: matrix-vector products
  logic signed [MV_W-1:0]      mv [9];

  // stage 2 input: matrix terms
  logic signed [MAT_W-1:0]     mat_next [9];

  // stage 4 input: rounded and clipped rows
  out_item_t                   res_next;

  // off-diagonal term: 2(a +/- b) rounded half up to the quaternion format
  function automatic logic signed [MAT_W-1:0] off_term(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b,
    input logic                     sub
  );
    logic signed [SUM_W-1:0] s;
    s = sub ? (SUM_W'(a) - SUM_W'(b)) : (SUM_W'(a) + SUM_W'(b));
    s = s + $signed(OFF_RND);
    return MAT_W'(s >>> (QUAT_FRAC - 1));
  endfunction

  // diagonal term: one minus 2(a + b), both squares
  function automatic logic signed [MAT_W-1:0] diag_term(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b} + OFF_RND;
    return $signed(DIAG_ONE - MAT_W'(s >> (QUAT_FRAC - 1)));
  endfunction

  // load enables ripple back from the output
  assign ld4      = !v4 || !out_stall;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_stall = !ld1;
  assign out_valid = v4;

  // matrix terms from the products
  always_comb begin
    mat_next[0] = diag_term(p_yy, p_zz);
    mat_next[1] = off_term(p_xy, p_wz, 1'b1);
    mat_next[2] = off_term(p_xz, p_wy, 1'b0);
    mat_next[3] = off_term(p_xy, p_wz, 1'b0);
    mat_next[4] = diag_term(p_xx, p_zz);
    mat_next[5] = off_term(p_yz, p_wx, 1'b1);
    mat_next[6] = off_term(p_xz, p_wy, 1'b1);
    mat_next[7] = off_term(p_yz, p_wx, 1'b0);
    mat_next[8] = diag_term(p_xx, p_yy);
  end

  // row sums, rounding and clipping
  always_comb begin
    logic signed [DOT_W-1:0]     dot;
    logic signed [RES_W-1:0]     r;
    logic signed [VEC_WIDTH-1:0] c [3];
    logic                        clip;
    logic                        any_clip;
    any_clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dot = DOT_W'(mv[3*i]) + DOT_W'(mv[3*i+1]) + DOT_W'(mv[3*i+2]) + $signed(DOT_RND);
      r   = RES_W'(dot >>> QUAT_FRAC);
      // out of range when the bits above the sign bit disagree with it
      clip = (r[RES_W-1:VEC_WIDTH-1] != {(RES_W-VEC_WIDTH+1){1'b0}}) &&
             (r[RES_W-1:VEC_WIDTH-1] != {(RES_W-VEC_WIDTH+1){1'b1}});
      if (clip) begin
        c[i] = r[RES_W-1] ? {1'b1, {(VEC_WIDTH-1){1'b0}}} : {1'b0, {(VEC_WIDTH-1){1'b1}}};
      end else begin
        c[i] = r[VEC_WIDTH-1:0];
      end
      any_clip = any_clip | clip;
    end
    res_next.rot_x     = c[0];
    res_next.rot_y     = c[1];
    res_next.rot_z     = c[2];
    res_next.saturated = any_clip;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  // stage 1: pair products
  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      p_wx    <= PROD_W'(in_data.qw) * PROD_W'(in_data.qx);
      p_wy    <= PROD_W'(in_data.qw) * PROD_W'(in_data.qy);
      p_wz    <= PROD_W'(in_data.qw) * PROD_W'(in_data.qz);
      p_xx    <= PROD_W'(in_data.qx) * PROD_W'(in_data.qx);
      p_yy    <= PROD_W'(in_data.qy) * PROD_W'(in_data.qy);
      p_zz    <= PROD_W'(in_data.qz) * PROD_W'(in_data.qz);
      p_xy    <= PROD_W'(in_data.qx) * PROD_W'(in_data.qy);
      p_xz    <= PROD_W'(in_data.qx) * PROD_W'(in_data.qz);
      p_yz    <= PROD_W'(in_data.qy) * PROD_W'(in_data.qz);
      vec1[0] <= in_data.vec_x;
      vec1[1] <= in_data.vec_y;
      vec1[2] <= in_data.vec_z;
    end
  end

  // stage 2: matrix terms
  always_ff @(posedge clk) begin
    if (ld2 && v1) begin
      for (int i = 0; i < 9; i++) mat[i] <= mat_next[i];
      for (int i = 0; i < 3; i++) vec2[i] <= vec1[i];
    end
  end

  // stage 3: matrix-vector products
  always_ff @(posedge clk) begin
    if (ld3 && v2) begin
      for (int i = 0; i < 9; i++) mv[i] <= MV_W'(mat[i]) * MV_W'(vec2[i % 3]);
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (ld4 && v3) begin
      out_data <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a component sitting at either end of the range
  logic lim_x, lim_y, lim_z;
  assign lim_x = (out_data.rot_x == {1'b1, {(VEC_WIDTH-1){1'b0}}}) ||
                 (out_data.rot_x == {1'b0, {(VEC_WIDTH-1){1'b1}}});
  assign lim_y = (out_data.rot_y == {1'b1, {(VEC_WIDTH-1){1'b0}}}) ||
                 (out_data.rot_y == {1'b0, {(VEC_WIDTH-1){1'b1}}});
  assign lim_z = (out_data.rot_z == {1'b1, {(VEC_WIDTH-1){1'b0}}}) ||
                 (out_data.rot_z == {1'b0, {(VEC_WIDTH-1){1'b1}}});

  // a flagged result has a clipped component
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |-> (lim_x || lim_y || lim_z))
    else $error("saturated flag without a clipped component");

  // an empty first stage never stalls the input
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> !in_stall)
    else $error("input stalled while first stage is empty");

  // a full pipeline behind a stalled output stalls the input
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && out_stall) |-> in_stall)
    else $error("input accepted into a full stalled pipeline");

  // an item leaving stage 3 arrives at the output
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v3 && ld4) |=> out_valid)
    else $error("item lost between stage 3 and the output");
`endif

endmodule

/* dv/testbench.sv */
// testbench: random and directed checks of the quaternion vector rotation pipeline
`timescale 1ns / 100ps

module testbench;
  import qrv_pkg::*;

  // tracks expected rotations and compares them with what the unit returns
  class rotation_scoreboard;
    out_item_t expected_q[$];
    int mismatches;
    int results_seen;
    int clipped_seen;

    // off-diagonal matrix term: 2(p1 +/- p2), rounded half up to Q1.15
    function longint skew_entry(longint sum);
      return (sum + (longint'(1) << (QUAT_FRAC - 2))) >>> (QUAT_FRAC - 1);
    endfunction

    // diagonal matrix term: 1 - 2(s1 + s2)
    function longint axis_entry(longint sq_a, longint sq_b);
      return (longint'(1) << QUAT_FRAC)
             - ((sq_a + sq_b + (longint'(1) << (QUAT_FRAC - 2))) >>> (QUAT_FRAC - 1));
    endfunction

    // rotated vector with saturation, as the unit should produce it
    function out_item_t rotate(in_item_t it);
      longint w, x, y, z, acc, hi_lim, lo_lim;
      longint vin[3];
      longint mat[9];
      longint rr[3];
      out_item_t res;
      int i;
      hi_lim = (longint'(1) << (VEC_WIDTH - 1)) - 1;
      lo_lim = -hi_lim - 1;
      w = $signed(it.qw);
      x = $signed(it.qx);
      y = $signed(it.qy);
      z = $signed(it.qz);
      vin[0] = $signed(it.vec_x);
      vin[1] = $signed(it.vec_y);
      vin[2] = $signed(it.vec_z);
      mat[0] = axis_entry(y * y, z * z);
      mat[1] = skew_entry(x * y - w * z);
      mat[2] = skew_entry(x * z + w * y);
      mat[3] = skew_entry(x * y + w * z);
      mat[4] = axis_entry(x * x, z * z);
      mat[5] = skew_entry(y * z - w * x);
      mat[6] = skew_entry(x * z - w * y);
      mat[7] = skew_entry(y * z + w * x);
      mat[8] = axis_entry(x * x, y * y);
      res.saturated = 1'b0;
      for (i = 0; i < 3; i++) begin
        acc = mat[3*i] * vin[0] + mat[3*i+1] * vin[1] + mat[3*i+2] * vin[2];
        acc = (acc + (longint'(1) << (QUAT_FRAC - 1))) >>> QUAT_FRAC;
        if (acc > hi_lim) begin
          acc = hi_lim;
          res.saturated = 1'b1;
        end else if (acc < lo_lim) begin
          acc = lo_lim;
          res.saturated = 1'b1;
        end
        rr[i] = acc;
      end
      res.rot_x = rr[0][VEC_WIDTH-1:0];
      res.rot_y = rr[1][VEC_WIDTH-1:0];
      res.rot_z = rr[2][VEC_WIDTH-1:0];
      return res;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(rotate(it));
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (want.saturated) clipped_seen++;
      if (got.rot_x !== want.rot_x) report("rot_x", want.rot_x, got.rot_x);
      if (got.rot_y !== want.rot_y) report("rot_y", want.rot_y, got.rot_y);
      if (got.rot_z !== want.rot_z) report("rot_z", want.rot_z, got.rot_z);
      if (got.saturated !== want.saturated) report("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  localparam int PHASE_ITEMS = 460;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  rotation_scoreboard board = new();

  quaternion_rotate_vector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watch both channels for accepted items
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_input(in_data);
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  // hold one item until the unit takes it, with random idle cycles first
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic in_item_t build(int w, int x, int y, int z, int vx, int vy, int vz);
    in_item_t it;
    it.qw = QUAT_WIDTH'(w);
    it.qx = QUAT_WIDTH'(x);
    it.qy = QUAT_WIDTH'(y);
    it.qz = QUAT_WIDTH'(z);
    it.vec_x = VEC_WIDTH'(vx);
    it.vec_y = VEC_WIDTH'(vy);
    it.vec_z = VEC_WIDTH'(vz);
    return it;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(5))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      4: return 16384;
      default: return 32767;
    endcase
  endfunction

  // mix of unit rotations, raw full-range items, extremes and small values
  function automatic in_item_t random_item();
    in_item_t it;
    real comp[4];
    real norm;
    int kind, i;
    kind = $urandom_range(99);
    it = build($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind < 45 || kind >= 85) begin
      norm = 0.0;
      for (i = 0; i < 4; i++) begin
        comp[i] = real'(int'($urandom_range(20000)) - 10000);
        norm += comp[i] * comp[i];
      end
      if (norm == 0.0) begin
        comp[0] = 1.0;
        norm = 1.0;
      end
      norm = $sqrt(norm);
      it.qw = QUAT_WIDTH'($rtoi(comp[0] / norm * 32767.0));
      it.qx = QUAT_WIDTH'($rtoi(comp[1] / norm * 32767.0));
      it.qy = QUAT_WIDTH'($rtoi(comp[2] / norm * 32767.0));
      it.qz = QUAT_WIDTH'($rtoi(comp[3] / norm * 32767.0));
      // small vectors exercise the rounding near zero
      if (kind >= 85) begin
        it.vec_x = VEC_WIDTH'(int'($urandom_range(127)) - 64);
        it.vec_y = VEC_WIDTH'(int'($urandom_range(127)) - 64);
        it.vec_z = VEC_WIDTH'(int'($urandom_range(127)) - 64);
      end
    end else if (kind >= 70) begin
      it = build(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme(), pick_extreme());
    end
    return it;
  endfunction

  // stimulus: directed corners, then random items over the idle/stall phases
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int ph;
    idle_tab = '{0, 70, 0, 23};
    stall_tab = '{0, 0, 70, 23};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // identity, half turns, quarter turns, most negative values, non-unit overflow
    send_item(build(32767, 0, 0, 0, 32767, -32768, 1));
    send_item(build(0, 0, 0, 0, 0, 0, 0));
    send_item(build(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(build(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(build(-32768, 0, 0, 0, -32768, 32767, -1));
    send_item(build(0, 32767, 0, 0, 100, 200, 300));
    send_item(build(0, 0, 32767, 0, -32768, -32768, -32768));
    send_item(build(0, 0, 0, -32768, 32767, 32767, 32767));
    send_item(build(23170, 0, 0, 23170, 32767, 0, -32768));
    send_item(build(23170, -23170, 0, 0, 0, 32767, 32767));
    send_item(build(32767, 32767, 32767, 32767, 32767, -32768, 32767));
    send_item(build(16384, 16384, 16384, 16384, -32768, 12345, -1));
    send_item(build(-1, 1, -1, 1, 32767, -32768, 0));
    send_item(build(0, -32768, -32768, 0, 1, -1, 32767));
    send_item(build(32767, -32768, 32767, -32768, -32768, -32768, 32767));
    send_item(build(12000, -30000, 5, -7, -1, -1, -1));

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    // drain, then give the four-stage pipe time to show any extra result
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("sent %0d items through four idle/stall phases after %0d directed corners",
             sent, 16);
    $display("checked %0d results, %0d of them saturated, %0d mismatches",
             board.results_seen, board.clipped_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results still pending", board.expected_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
